>>> hdl/ippf_pkg.sv
// Package for the identity policy packet filter.
// Holds the transfer structs, item modes, engine states and frame constants.
// No dependencies.
`default_nettype none

package ippf_pkg;

   localparam int ID_ENTRIES_DEF  = 64;
   localparam int POL_ENTRIES_DEF = 64;

   // item modes
   localparam logic [1:0] MODE_FRAME  = 2'd0;
   localparam logic [1:0] MODE_ID_WR  = 2'd1;
   localparam logic [1:0] MODE_POL_WR = 2'd2;

   // frame layout and header codes
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [15:0] OFS_TYPE_HI    = 16'd12;
   localparam logic [15:0] OFS_TYPE_LO    = 16'd13;
   localparam logic [15:0] OFS_PROTO      = 16'd23;
   localparam logic [15:0] OFS_SRC_FIRST  = 16'd26;
   localparam logic [15:0] OFS_SRC_LAST   = 16'd29;
   localparam logic [15:0] OFS_DST_FIRST  = 16'd30;
   localparam logic [15:0] OFS_DST_LAST   = 16'd33;
   localparam logic [15:0] OFS_PORT_HI    = 16'd36;
   localparam logic [15:0] OFS_PORT_LO    = 16'd37;
   localparam logic [15:0] MIN_LEN_IP     = 16'd34;
   localparam logic [15:0] MIN_LEN_UDP    = 16'd42;
   localparam logic [15:0] MIN_LEN_TCP    = 16'd54;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [5:0]  entry_slot;
      logic        entry_valid;
      logic [31:0] key_ip;
      logic [31:0] identity_id;
      logic [31:0] rule_src_id;
      logic [31:0] rule_dst_id;
      logic [7:0]  rule_proto;
      logic [15:0] rule_port;
      logic        rule_allow;
   } req_type;

   typedef struct packed {
      logic        classified;
      logic        drop;
      logic        rule_hit;
      logic [31:0] src_group;
      logic [31:0] dst_group;
      logic [7:0]  protocol;
      logic [15:0] port;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ID_SCAN,
      ST_POL_SCAN,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

>>> hdl/identity_policy_packet_filter_core.sv
// Top level of the identity policy packet filter: frame parser, identity and
// policy memories, scan engine and result register. Depends on ippf_pkg.
`default_nettype none

// Frame bytes are taken one per cycle while req_stall is low. On the last
// byte of a frame the key is latched; if the frame passes the length and
// type checks, a scan engine walks the identity memory (both addresses at
// once) and then the policy memory (stopping at the first match), else no
// scan runs. Bytes of the next frame keep flowing during the scan; its last
// byte and any table write wait until the result is loaded. After reset a
// clearing pass zeroes both memories and no item is taken meanwhile.
// Results sit in an output register, so a stalled result does not hold up
// input bytes; a second result waits in ST_OUT while the first is stalled.
module identity_policy_packet_filter_core
   import ippf_pkg::*;
#(
   parameter int IDENTITY_ENTRIES = ID_ENTRIES_DEF,
   parameter int POLICY_ENTRIES   = POL_ENTRIES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int MAXN = (IDENTITY_ENTRIES > POLICY_ENTRIES) ?
                         IDENTITY_ENTRIES : POLICY_ENTRIES;
   localparam int CW   = $clog2(MAXN + 1);
   localparam int IIW  = (IDENTITY_ENTRIES > 1) ? $clog2(IDENTITY_ENTRIES) : 1;
   localparam int PIW  = (POLICY_ENTRIES > 1) ? $clog2(POLICY_ENTRIES) : 1;
   localparam int IDW  = 65;   // valid, address, identity
   localparam int POLW = 90;   // valid, allow, src, dst, proto, port

   // memories
   logic [IDW-1:0]  id_mem  [IDENTITY_ENTRIES];
   logic [POLW-1:0] pol_mem [POLICY_ENTRIES];
   logic [IDW-1:0]  id_rd_ff;
   logic [POLW-1:0] pol_rd_ff;

   logic            id_we, pol_we;
   logic [IIW-1:0]  id_waddr;
   logic [PIW-1:0]  pol_waddr;
   logic [IDW-1:0]  id_wdata;
   logic [POLW-1:0] pol_wdata;

   // control
   state_type  state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic       rv_ff, rv_in;
   logic       accept, busy, slot_id_ok, slot_pol_ok, frame_end;

   // frame capture
   logic [15:0] count_ff, count_in;
   logic [15:0] ftype_ff, ftype_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [15:0] dport_ff, dport_in;
   logic        frame_ok;
   logic [15:0] frame_port;

   // scan key and result
   logic        ok_ff, ok_in;
   logic [31:0] key_src_ff, key_src_in, key_dst_ff, key_dst_in;
   logic [7:0]  key_proto_ff, key_proto_in;
   logic [15:0] key_port_ff, key_port_in;
   logic [31:0] sid_ff, sid_in, did_ff, did_in;
   logic        sfound_ff, sfound_in, dfound_ff, dfound_in;
   logic        match_ff, match_in, allow_ff, allow_in;

   logic        rsp_valid_ff, rsp_valid_in, rsp_load;
   rsp_type     rsp_ff, rsp_in;

   // handshake
   assign busy      = (state_ff != ST_IDLE);
   assign req_stall = (state_ff == ST_CLEAR) ||
                      (busy && !(req_data.mode == MODE_FRAME && !req_data.last_byte));
   assign accept    = req_valid && !req_stall;
   assign frame_end = accept && req_data.mode == MODE_FRAME && req_data.last_byte;

   assign slot_id_ok  = ({11'd0, req_data.entry_slot} < 17'(IDENTITY_ENTRIES));
   assign slot_pol_ok = ({11'd0, req_data.entry_slot} < 17'(POLICY_ENTRIES));

   // frame byte capture
   always_comb begin
      count_in = count_ff;
      ftype_in = ftype_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      dport_in = dport_ff;
      if (accept && req_data.mode == MODE_FRAME) begin
         if (count_ff == OFS_TYPE_HI) ftype_in = {req_data.data_byte, ftype_ff[7:0]};
         else if (count_ff == OFS_TYPE_LO) ftype_in = {ftype_ff[15:8], req_data.data_byte};
         else if (count_ff == OFS_PROTO) proto_in = req_data.data_byte;
         else if (count_ff >= OFS_SRC_FIRST && count_ff <= OFS_SRC_LAST)
            src_in = {src_ff[23:0], req_data.data_byte};
         else if (count_ff >= OFS_DST_FIRST && count_ff <= OFS_DST_LAST)
            dst_in = {dst_ff[23:0], req_data.data_byte};
         else if (count_ff == OFS_PORT_HI) dport_in = {req_data.data_byte, dport_ff[7:0]};
         else if (count_ff == OFS_PORT_LO) dport_in = {dport_ff[15:8], req_data.data_byte};
         if (count_ff != 16'hFFFF) count_in = count_ff + 16'd1;
      end
   end

   // frame check on the updated capture
   always_comb begin
      frame_ok   = (count_in >= MIN_LEN_IP) && (ftype_in == ETHERTYPE_IPV4);
      frame_port = 16'd0;
      if (proto_in == PROTO_TCP) begin
         frame_ok   = frame_ok && (count_in >= MIN_LEN_TCP);
         frame_port = dport_in;
      end else if (proto_in == PROTO_UDP) begin
         frame_ok   = frame_ok && (count_in >= MIN_LEN_UDP);
         frame_port = dport_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || frame_end) begin
         count_ff <= '0;
         ftype_ff <= '0;
         proto_ff <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
         dport_ff <= '0;
      end else begin
         count_ff <= count_in;
         ftype_ff <= ftype_in;
         proto_ff <= proto_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         dport_ff <= dport_in;
      end
   end

   // memory write select: clearing pass or table write transfer
   always_comb begin
      id_we     = 1'b0;
      pol_we    = 1'b0;
      id_waddr  = IIW'({10'd0, req_data.entry_slot});
      pol_waddr = PIW'({10'd0, req_data.entry_slot});
      id_wdata  = {req_data.entry_valid, req_data.key_ip, req_data.identity_id};
      pol_wdata = {req_data.entry_valid, req_data.rule_allow, req_data.rule_src_id,
                   req_data.rule_dst_id, req_data.rule_proto, req_data.rule_port};
      if (state_ff == ST_CLEAR) begin
         id_we     = (cnt_ff < CW'(IDENTITY_ENTRIES));
         pol_we    = (cnt_ff < CW'(POLICY_ENTRIES));
         id_waddr  = cnt_ff[IIW-1:0];
         pol_waddr = cnt_ff[PIW-1:0];
         id_wdata  = '0;
         pol_wdata = '0;
      end else if (accept) begin
         id_we  = (req_data.mode == MODE_ID_WR) && slot_id_ok;
         pol_we = (req_data.mode == MODE_POL_WR) && slot_pol_ok;
      end
   end

   // memories: one write, one registered read
   always_ff @(posedge clock) begin
      if (id_we) id_mem[id_waddr] <= id_wdata;
      id_rd_ff <= id_mem[cnt_ff[IIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (pol_we) pol_mem[pol_waddr] <= pol_wdata;
      pol_rd_ff <= pol_mem[cnt_ff[PIW-1:0]];
   end

   // scan engine
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rv_in        = 1'b0;
      ok_in        = ok_ff;
      key_src_in   = key_src_ff;
      key_dst_in   = key_dst_ff;
      key_proto_in = key_proto_ff;
      key_port_in  = key_port_ff;
      sid_in       = sid_ff;
      did_in       = did_ff;
      sfound_in    = sfound_ff;
      dfound_in    = dfound_ff;
      match_in     = match_ff;
      allow_in     = allow_ff;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(MAXN - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (frame_end) begin
               ok_in        = frame_ok;
               key_src_in   = src_in;
               key_dst_in   = dst_in;
               key_proto_in = frame_ok ? proto_in : 8'd0;
               key_port_in  = frame_ok ? frame_port : 16'd0;
               sid_in       = '0;
               did_in       = '0;
               sfound_in    = 1'b0;
               dfound_in    = 1'b0;
               match_in     = 1'b0;
               allow_in     = 1'b1;
               cnt_in       = '0;
               state_in     = frame_ok ? ST_ID_SCAN : ST_OUT;
            end
         end
         ST_ID_SCAN: begin
            if (cnt_ff < CW'(IDENTITY_ENTRIES)) begin
               cnt_in = cnt_ff + CW'(1);
               rv_in  = 1'b1;
            end else if (!rv_ff) begin
               cnt_in   = '0;
               state_in = ST_POL_SCAN;
            end
            if (rv_ff && id_rd_ff[64]) begin
               if (!sfound_ff && id_rd_ff[63:32] == key_src_ff) begin
                  sfound_in = 1'b1;
                  sid_in    = id_rd_ff[31:0];
               end
               if (!dfound_ff && id_rd_ff[63:32] == key_dst_ff) begin
                  dfound_in = 1'b1;
                  did_in    = id_rd_ff[31:0];
               end
            end
         end
         ST_POL_SCAN: begin
            if (cnt_ff < CW'(POLICY_ENTRIES)) begin
               cnt_in = cnt_ff + CW'(1);
               rv_in  = 1'b1;
            end else if (!rv_ff) begin
               state_in = ST_OUT;
            end
            if (rv_ff && pol_rd_ff[89] && pol_rd_ff[87:0] ==
                  {sid_ff, did_ff, key_proto_ff, key_port_ff}) begin
               match_in = 1'b1;
               allow_in = pol_rd_ff[88];
               rv_in    = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff        <= ok_in;
      key_src_ff   <= key_src_in;
      key_dst_ff   <= key_dst_in;
      key_proto_ff <= key_proto_in;
      key_port_ff  <= key_port_in;
      sid_ff       <= sid_in;
      did_ff       <= did_in;
      sfound_ff    <= sfound_in;
      dfound_ff    <= dfound_in;
      match_ff     <= match_in;
      allow_ff     <= allow_in;
   end

   // result register
   always_comb begin
      rsp_in.classified = ok_ff;
      rsp_in.drop       = ok_ff && !allow_ff;
      rsp_in.rule_hit   = match_ff;
      rsp_in.src_group  = sid_ff;
      rsp_in.dst_group  = did_ff;
      rsp_in.protocol   = key_proto_ff;
      rsp_in.port       = key_port_ff;
      rsp_valid_in      = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // no table write or frame end while a scan runs
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && busy) |-> (req_data.mode == MODE_FRAME && !req_data.last_byte))
      else $error("table write or frame end taken during scan");

   // nothing taken during the clearing pass
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !accept)
      else $error("transfer during clearing pass");

   // a waiting result is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("stalled result overwritten");

   // scan counter never exceeds the larger table size
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ID_SCAN || state_ff == ST_POL_SCAN) |-> (cnt_ff <= CW'(MAXN)))
      else $error("scan counter out of range");
`endif

endmodule

`default_nettype wire

>>> tb/identity_policy_packet_filter_checker.sv
// Checker for the identity policy packet filter: watches both channels,
// predicts each frame verdict from its own copy of the tables, compares.
// Depends on ippf_pkg.
`default_nettype none

module identity_policy_packet_filter_checker
   import ippf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           error_count,
   output int           verdicts_pending
);

   // shadow tables
   logic [31:0] id_addr [64];
   logic [31:0] id_value [64];
   logic        id_live [64];
   logic [31:0] rule_src [64];
   logic [31:0] rule_dst [64];
   logic [7:0]  rule_proto [64];
   logic [15:0] rule_port [64];
   logic        rule_allow [64];
   logic        rule_live [64];

   // per-frame capture
   logic [15:0] frame_len;
   logic [15:0] ether_type;
   logic [7:0]  ip_proto;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [15:0] dst_port;

   rsp_type verdict_queue [$];

   assign verdicts_pending = verdict_queue.size();

   function automatic logic [31:0] identity_lookup(logic [31:0] addr);
      for (int i = 0; i < 64; i++)
         if (id_live[i] && id_addr[i] == addr) return id_value[i];
      return 32'd0;
   endfunction

   function automatic rsp_type frame_verdict();
      rsp_type v;
      logic    ok;
      v = '0;
      ok = 1'b1;
      if (frame_len < MIN_LEN_IP || ether_type != ETHERTYPE_IPV4) ok = 1'b0;
      else if (ip_proto == PROTO_TCP) begin
         if (frame_len < MIN_LEN_TCP) ok = 1'b0; else v.port = dst_port;
      end else if (ip_proto == PROTO_UDP) begin
         if (frame_len < MIN_LEN_UDP) ok = 1'b0; else v.port = dst_port;
      end
      if (!ok) return '0;
      v.classified = 1'b1;
      v.src_group = identity_lookup(src_addr);
      v.dst_group = identity_lookup(dst_addr);
      v.protocol = ip_proto;
      for (int i = 0; i < 64; i++) begin
         if (rule_live[i] && rule_src[i] == v.src_group
               && rule_dst[i] == v.dst_group && rule_proto[i] == ip_proto
               && rule_port[i] == v.port) begin
            v.rule_hit = 1'b1;
            v.drop = !rule_allow[i];
            break;
         end
      end
      return v;
   endfunction

   // input side: update shadow state on each transfer
   always @(posedge clock) begin
      if (reset) begin
         frame_len = '0; ether_type = '0; ip_proto = '0;
         src_addr = '0; dst_addr = '0; dst_port = '0;
         for (int i = 0; i < 64; i++) begin
            id_live[i] = 1'b0;
            rule_live[i] = 1'b0;
         end
      end else if (req_valid && !req_stall) begin
         case (req_data.mode)
            MODE_FRAME: begin
               case (frame_len)
                  OFS_TYPE_HI: ether_type[15:8] = req_data.data_byte;
                  OFS_TYPE_LO: ether_type[7:0] = req_data.data_byte;
                  OFS_PROTO:   ip_proto = req_data.data_byte;
                  OFS_PORT_HI: dst_port[15:8] = req_data.data_byte;
                  OFS_PORT_LO: dst_port[7:0] = req_data.data_byte;
                  default: begin
                     if (frame_len >= OFS_SRC_FIRST && frame_len <= OFS_SRC_LAST)
                        src_addr = {src_addr[23:0], req_data.data_byte};
                     else if (frame_len >= OFS_DST_FIRST && frame_len <= OFS_DST_LAST)
                        dst_addr = {dst_addr[23:0], req_data.data_byte};
                  end
               endcase
               if (frame_len != 16'hFFFF) frame_len = frame_len + 16'd1;
               if (req_data.last_byte) begin
                  verdict_queue.push_back(frame_verdict());
                  frame_len = '0; ether_type = '0; ip_proto = '0;
                  src_addr = '0; dst_addr = '0; dst_port = '0;
               end
            end
            MODE_ID_WR: begin
               id_addr[req_data.entry_slot] = req_data.key_ip;
               id_value[req_data.entry_slot] = req_data.identity_id;
               id_live[req_data.entry_slot] = req_data.entry_valid;
            end
            MODE_POL_WR: begin
               rule_src[req_data.entry_slot] = req_data.rule_src_id;
               rule_dst[req_data.entry_slot] = req_data.rule_dst_id;
               rule_proto[req_data.entry_slot] = req_data.rule_proto;
               rule_port[req_data.entry_slot] = req_data.rule_port;
               rule_allow[req_data.entry_slot] = req_data.rule_allow;
               rule_live[req_data.entry_slot] = req_data.entry_valid;
            end
            default: ;
         endcase
      end
   end

   // result side: compare against the oldest predicted verdict
   always @(posedge clock) begin
      rsp_type exp_v;
      if (reset) begin
         error_count <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (verdict_queue.size() == 0) begin
            $error("unexpected result transfer");
            error_count <= error_count + 1;
         end else begin
            exp_v = verdict_queue.pop_front();
            if (exp_v != rsp_data) begin
               if (exp_v.classified != rsp_data.classified)
                  $error("classified: expected %0d actual %0d",
                     exp_v.classified, rsp_data.classified);
               if (exp_v.drop != rsp_data.drop)
                  $error("drop: expected %0d actual %0d", exp_v.drop, rsp_data.drop);
               if (exp_v.rule_hit != rsp_data.rule_hit)
                  $error("rule_hit: expected %0d actual %0d",
                     exp_v.rule_hit, rsp_data.rule_hit);
               if (exp_v.src_group != rsp_data.src_group)
                  $error("src_group: expected %h actual %h",
                     exp_v.src_group, rsp_data.src_group);
               if (exp_v.dst_group != rsp_data.dst_group)
                  $error("dst_group: expected %h actual %h",
                     exp_v.dst_group, rsp_data.dst_group);
               if (exp_v.protocol != rsp_data.protocol)
                  $error("protocol: expected %0d actual %0d",
                     exp_v.protocol, rsp_data.protocol);
               if (exp_v.port != rsp_data.port)
                  $error("port: expected %0d actual %0d", exp_v.port, rsp_data.port);
               error_count <= error_count + 1;
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> tb/identity_policy_packet_filter_core_test.sv
// Stimulus and verdict for the identity policy packet filter: sends frames
// and table writes with random idling. Depends on ippf_pkg, the checker and the core.
`default_nettype none

module identity_policy_packet_filter_core_test;
   import ippf_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      error_count;
   int      verdicts_pending;
   int      items_sent = 0;
   bit      calm = 1'b0;

   // small address and identity pools so lookups hit often
   logic [31:0] addr_pool [8];
   logic [31:0] ident_pool [4];

   always #5 clock = ~clock;

   identity_policy_packet_filter_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   identity_policy_packet_filter_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .error_count(error_count), .verdicts_pending(verdicts_pending)
   );

   // one transfer, with an optional random gap first
   task automatic send_item(req_type item);
      int gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic write_identity(int slot, logic [31:0] addr, logic [31:0] ident, bit live);
      req_type item;
      item = '0;
      item.mode = MODE_ID_WR;
      item.entry_slot = 6'(slot);
      item.entry_valid = live;
      item.key_ip = addr;
      item.identity_id = ident;
      send_item(item);
   endtask

   task automatic write_rule(int slot, logic [31:0] src_id, logic [31:0] dst_id,
                             logic [7:0] proto, logic [15:0] port, bit allow, bit live);
      req_type item;
      item = '0;
      item.mode = MODE_POL_WR;
      item.entry_slot = 6'(slot);
      item.entry_valid = live;
      item.rule_src_id = src_id;
      item.rule_dst_id = dst_id;
      item.rule_proto = proto;
      item.rule_port = port;
      item.rule_allow = allow;
      send_item(item);
   endtask

   // a frame of len bytes; junk bits in unused fields are random
   task automatic send_frame(int len, logic [15:0] etype, logic [7:0] proto,
                             logic [31:0] src, logic [31:0] dst, logic [15:0] port);
      req_type item;
      logic [7:0] b;
      logic [191:0] junk;
      for (int n = 0; n < len; n++) begin
         b = 8'($urandom_range(0, 255));
         case (n)
            12: b = etype[15:8];
            13: b = etype[7:0];
            23: b = proto;
            26: b = src[31:24];
            27: b = src[23:16];
            28: b = src[15:8];
            29: b = src[7:0];
            30: b = dst[31:24];
            31: b = dst[23:16];
            32: b = dst[15:8];
            33: b = dst[7:0];
            36: b = port[15:8];
            37: b = port[7:0];
            default: ;
         endcase
         junk = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         item = junk[$bits(req_type)-1:0];
         item.mode = MODE_FRAME;
         item.data_byte = b;
         item.last_byte = (n == len - 1);
         send_item(item);
      end
   endtask

   function automatic logic [7:0] pick_proto();
      case ($urandom_range(0, 3))
         0: return PROTO_TCP;
         1: return PROTO_UDP;
         2: return 8'd1;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // random stall bursts on the result side
   initial begin
      @(negedge clock);
      while (1) begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(negedge clock);
      end
   end

   // watchdog
   initial begin
      #20000000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      req_type item;
      int len;
      int wait_count;
      logic [7:0] proto;
      for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
      for (int i = 0; i < 4; i++) ident_pool[i] = $urandom_range(1, 5);
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed: table extremes, duplicates, removal, each frame case
      write_identity(0, addr_pool[0], ident_pool[0], 1'b1);
      write_identity(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      write_identity(5, addr_pool[0], 32'h1234, 1'b1);    // shadowed duplicate
      write_identity(6, addr_pool[1], ident_pool[1], 1'b1);
      write_rule(0, ident_pool[0], ident_pool[1], PROTO_TCP, 16'd80, 1'b0, 1'b1);
      write_rule(1, ident_pool[0], ident_pool[1], PROTO_TCP, 16'd80, 1'b1, 1'b1);
      write_rule(63, 32'hFFFF_FFFF, 32'd0, 8'hFF, 16'hFFFF, 1'b0, 1'b1);
      write_rule(2, 32'd0, 32'd0, PROTO_UDP, 16'd53, 1'b0, 1'b1);
      send_frame(60, ETHERTYPE_IPV4, PROTO_TCP, addr_pool[0], addr_pool[1], 16'd80);
      send_frame(1, 16'h0000, 8'd0, 32'd0, 32'd0, 16'd0);
      send_frame(13, ETHERTYPE_IPV4, 8'd0, 32'd0, 32'd0, 16'd0);
      send_frame(33, ETHERTYPE_IPV4, 8'd0, 32'd0, 32'd0, 16'd0);
      send_frame(53, ETHERTYPE_IPV4, PROTO_TCP, 32'd0, 32'd0, 16'd0);
      send_frame(41, ETHERTYPE_IPV4, PROTO_UDP, 32'd0, 32'd0, 16'd53);
      send_frame(42, ETHERTYPE_IPV4, PROTO_UDP, 32'h5, 32'h6, 16'd53);
      send_frame(40, 16'h86DD, PROTO_TCP, 32'd0, 32'd0, 16'd0);
      send_frame(34, ETHERTYPE_IPV4, 8'hFF, 32'hFFFF_FFFF, addr_pool[2], 16'hFFFF);
      item = '1;                                            // unused mode
      send_item(item);
      write_rule(0, 32'd0, 32'd0, 8'd0, 16'd0, 1'b0, 1'b0); // remove slot
      send_frame(54, ETHERTYPE_IPV4, PROTO_TCP, addr_pool[0], addr_pool[1], 16'd80);

      // random: mostly well-formed IPv4 frames, interleaved table writes
      while (items_sent < 1550) begin
         if (items_sent > 1300) calm = 1'b1;
         case ($urandom_range(0, 9))
            0: write_identity($urandom_range(0, 63),
                  ($urandom_range(0, 3) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)],
                  ident_pool[$urandom_range(0, 3)], $urandom_range(0, 4) != 0);
            1: begin
               proto = pick_proto();
               write_rule($urandom_range(0, 63), ident_pool[$urandom_range(0, 3)],
                  ($urandom_range(0, 3) == 0) ? 32'd0 : ident_pool[$urandom_range(0, 3)],
                  proto, (proto == PROTO_TCP || proto == PROTO_UDP) ?
                  16'($urandom_range(0, 3)) : 16'd0,
                  1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0);
            end
            2: send_frame($urandom_range(1, 60),
                  ($urandom_range(0, 1)) ? ETHERTYPE_IPV4 : 16'($urandom),
                  pick_proto(), $urandom, $urandom, 16'($urandom));
            default: begin
               proto = pick_proto();
               len = (proto == PROTO_TCP) ? $urandom_range(54, 64) : $urandom_range(42, 50);
               send_frame(len, ETHERTYPE_IPV4, proto,
                  addr_pool[$urandom_range(0, 7)], addr_pool[$urandom_range(0, 7)],
                  16'($urandom_range(0, 3)));
            end
         endcase
      end
      req_valid <= 1'b0;

      // drain
      wait_count = 0;
      while (verdicts_pending != 0 && wait_count < 100000) begin
         @(negedge clock);
         wait_count++;
      end
      repeat (200) @(negedge clock);
      if (error_count == 0 && verdicts_pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

>>> identity_policy_packet_filter_core.f
hdl/ippf_pkg.sv
hdl/identity_policy_packet_filter_core.sv
tb/identity_policy_packet_filter_checker.sv
tb/identity_policy_packet_filter_core_test.sv
